>>> hdl/rc4_pkg.sv
`default_nettype none

package rc4_pkg;

	localparam int unsigned KeyLength = 256;
	localparam logic [7:0]  KeyLast   = 8'(KeyLength - 1);

	localparam logic OpKeyLoad = 1'b0;
	localparam logic OpData    = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] key_index;
		logic [7:0] data_byte;
		logic       zone_end;
	} cmd_t;

	typedef struct packed {
		logic [7:0] result_byte;
		logic       unkeyed;
		logic       zone_end_out;
	} rsp_t;

endpackage

`default_nettype wire

>>> hdl/rc4_stream_cipher_core.sv
`default_nettype none

// RC4 cipher core. A key-load item (operation 0) stores one key byte at
// key_index; writing index KeyLength-1 starts the key schedule, which fills
// the permutation with the identity, then runs each mixing step through the
// MRD, MJ, MW1 and MW2 states; cmd_stall is high throughout. Each data item
// (operation 1) returns one result: the byte XORed with the next keystream
// byte, or the byte unchanged with unkeyed set if no schedule has completed
// since reset or since the last data item with zone_end. A keyed data item
// passes through PI, PJ, PW1, PW2, PX and OUT before it reaches the result
// register, an unkeyed one goes straight to OUT, and the input side stays
// busy until the result is loaded; other key loads leave it idle. This span
// is set by the single read and single write port of the permutation
// memory, which the dependent S[i], S[j], S[S[i]+S[j]] accesses and the
// two-write swap share. The result register frees the input side once the
// result is loaded, even while rsp_stall holds it.
module rc4_stream_cipher_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire rc4_pkg::cmd_t cmd,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output rc4_pkg::rsp_t      rsp
);
	import rc4_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_INIT = 12'b0000_0000_0010,
		ST_MRD  = 12'b0000_0000_0100,
		ST_MJ   = 12'b0000_0000_1000,
		ST_MW1  = 12'b0000_0001_0000,
		ST_MW2  = 12'b0000_0010_0000,
		ST_PI   = 12'b0000_0100_0000,
		ST_PJ   = 12'b0000_1000_0000,
		ST_PW1  = 12'b0001_0000_0000,
		ST_PW2  = 12'b0010_0000_0000,
		ST_PX   = 12'b0100_0000_0000,
		ST_OUT  = 12'b1000_0000_0000
	} state_t;

	state_t     state_q;
	logic [7:0] n_q, kc_q, acc_q;
	logic [7:0] i_q, j_q;
	logic       keyed_q;
	logic [7:0] si_q, sj_q, sn_q;
	logic       byp_q;
	logic [7:0] data_q, res_q;
	logic       unk_q, ze_q;

	logic [7:0] perm_mem [256];
	logic [7:0] key_mem  [256];
	logic       p_we;
	logic [7:0] p_wa, p_wd, p_ra, p_rd_q;
	logic [7:0] k_rd_q;

	logic       accept;
	logic       rsp_load;
	logic [7:0] acc_nx, i_nx, j_nx, t_nx;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign rsp_load  = (state_q == ST_OUT) && (!rsp_valid || !rsp_stall);

	assign acc_nx = 8'(acc_q + p_rd_q + k_rd_q);
	assign i_nx   = 8'(i_q + 8'd1);
	assign j_nx   = 8'(j_q + p_rd_q);
	assign t_nx   = 8'(si_q + sj_q);

	always_comb begin
		p_we = 1'b0;
		p_wa = n_q;
		p_wd = n_q;
		p_ra = n_q;
		unique case (state_q)
			ST_INIT: begin
				p_we = 1'b1;
			end
			ST_MJ: begin
				p_ra = acc_nx;
			end
			ST_MW1: begin
				p_we = 1'b1;
				p_wd = p_rd_q;
			end
			ST_MW2: begin
				p_we = 1'b1;
				p_wa = acc_q;
				p_wd = sn_q;
			end
			ST_PI: begin
				p_ra = i_nx;
			end
			ST_PJ: begin
				p_ra = j_nx;
			end
			ST_PW1: begin
				p_we = 1'b1;
				p_wa = i_q;
				p_wd = p_rd_q;
			end
			ST_PW2: begin
				p_we = 1'b1;
				p_wa = j_q;
				p_wd = si_q;
				p_ra = t_nx;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			perm_mem[p_wa] <= p_wd;
		end
		p_rd_q <= perm_mem[p_ra];
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.operation == OpKeyLoad) begin
			key_mem[cmd.key_index] <= cmd.data_byte;
		end
		k_rd_q <= key_mem[kc_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			n_q       <= '0;
			kc_q      <= '0;
			acc_q     <= '0;
			i_q       <= '0;
			j_q       <= '0;
			keyed_q   <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid <= 1'b1;
			end else if (rsp_valid && !rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.operation == OpKeyLoad) begin
							if (cmd.key_index == KeyLast) begin
								n_q     <= '0;
								state_q <= ST_INIT;
							end
						end else begin
							if (cmd.zone_end) begin
								keyed_q <= 1'b0;
							end
							state_q <= keyed_q ? ST_PI : ST_OUT;
						end
					end
				end
				ST_INIT: begin
					n_q <= 8'(n_q + 8'd1);
					if (n_q == 8'hff) begin
						kc_q    <= '0;
						acc_q   <= '0;
						state_q <= ST_MRD;
					end
				end
				ST_MRD: begin
					state_q <= ST_MJ;
				end
				ST_MJ: begin
					acc_q   <= acc_nx;
					state_q <= ST_MW1;
				end
				ST_MW1: begin
					state_q <= ST_MW2;
				end
				ST_MW2: begin
					n_q  <= 8'(n_q + 8'd1);
					kc_q <= (kc_q == KeyLast) ? 8'd0 : 8'(kc_q + 8'd1);
					if (n_q == 8'hff) begin
						i_q     <= '0;
						j_q     <= '0;
						keyed_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_MRD;
					end
				end
				ST_PI: begin
					i_q     <= i_nx;
					state_q <= ST_PJ;
				end
				ST_PJ: begin
					j_q     <= j_nx;
					state_q <= ST_PW1;
				end
				ST_PW1: begin
					state_q <= ST_PW2;
				end
				ST_PW2: begin
					state_q <= ST_PX;
				end
				ST_PX: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= cmd.data_byte;
			ze_q   <= cmd.zone_end;
			unk_q  <= !keyed_q;
			res_q  <= cmd.data_byte;
		end
		if (state_q == ST_MJ) begin
			sn_q <= p_rd_q;
		end
		if (state_q == ST_PJ) begin
			si_q <= p_rd_q;
		end
		if (state_q == ST_PW1) begin
			sj_q <= p_rd_q;
		end
		if (state_q == ST_PW2) begin
			byp_q <= (t_nx == j_q);
		end
		if (state_q == ST_PX) begin
			res_q <= data_q ^ (byp_q ? si_q : p_rd_q);
		end
		if (rsp_load) begin
			rsp.result_byte  <= res_q;
			rsp.unkeyed      <= unk_q;
			rsp.zone_end_out <= ze_q;
		end
	end

	a_sched_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.operation == OpKeyLoad && cmd.key_index == KeyLast
		|=> state_q == ST_INIT)
		else $error("key schedule did not start after last key byte");

	a_keyed_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(keyed_q) |-> $past(state_q == ST_MW2))
		else $error("keyed set outside end of key schedule");

	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside output state");

endmodule

`default_nettype wire

>>> tb/sv/rc4_stream_cipher_checker.sv
module rc4_stream_cipher_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire logic          cmd_stall,
	input  wire rc4_pkg::cmd_t cmd,
	input  wire logic          rsp_valid,
	input  wire logic          rsp_stall,
	input  wire rc4_pkg::rsp_t rsp,
	output int unsigned        fail_cnt,
	output int unsigned        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import rc4_pkg::*;

	logic [7:0] sbox [256];
	logic [7:0] key_mem [256];
	logic [7:0] ks_i;
	logic [7:0] ks_j;
	logic       keyed_q;
	rsp_t       cipher_rsp_q [$];

	function automatic void swap_sbox(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] t;
		t = sbox[a];
		sbox[a] = sbox[b];
		sbox[b] = t;
	endfunction

	function automatic void run_key_schedule();
		logic [7:0] acc;
		acc = 8'h00;
		for (int n = 0; n < 256; n++)
			sbox[n] = 8'(n);
		for (int n = 0; n < 256; n++) begin
			acc = acc + sbox[n] + key_mem[8'(n % KeyLength)];
			swap_sbox(8'(n), acc);
		end
		ks_i = 8'h00;
		ks_j = 8'h00;
		keyed_q = 1'b1;
	endfunction

	function automatic rsp_t next_cipher_rsp(input cmd_t c);
		rsp_t r;
		logic [7:0] t;
		if (keyed_q) begin
			ks_i = ks_i + 8'd1;
			ks_j = ks_j + sbox[ks_i];
			swap_sbox(ks_i, ks_j);
			t = sbox[ks_i] + sbox[ks_j];
			r.result_byte = c.data_byte ^ sbox[t];
			r.unkeyed = 1'b0;
		end else begin
			r.result_byte = c.data_byte;
			r.unkeyed = 1'b1;
		end
		r.zone_end_out = c.zone_end;
		if (c.zone_end)
			keyed_q = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			ks_i = 8'h00;
			ks_j = 8'h00;
			keyed_q = 1'b0;
			cipher_rsp_q.delete();
			fail_cnt = 0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				if (cmd.operation == OpKeyLoad) begin
					key_mem[cmd.key_index] = cmd.data_byte;
					if (cmd.key_index == KeyLast)
						run_key_schedule();
				end else begin
					cipher_rsp_q.push_back(next_cipher_rsp(cmd));
				end
			end
			if (rsp_valid && !rsp_stall) begin
				if (cipher_rsp_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("%0t: unexpected rsp byte=%02h unkeyed=%0d zone_end=%0d",
							$realtime, rsp.result_byte, rsp.unkeyed, rsp.zone_end_out);
				end else begin
					exp_rsp = cipher_rsp_q.pop_front();
					if (rsp.result_byte !== exp_rsp.result_byte ||
					    rsp.unkeyed !== exp_rsp.unkeyed ||
					    rsp.zone_end_out !== exp_rsp.zone_end_out) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display("%0t: rsp mismatch exp %02h/%0d/%0d got %02h/%0d/%0d",
								$realtime,
								exp_rsp.result_byte, exp_rsp.unkeyed, exp_rsp.zone_end_out,
								rsp.result_byte, rsp.unkeyed, rsp.zone_end_out);
					end
				end
			end
		end
		pending = cipher_rsp_q.size();
	end

endmodule

>>> tb/sv/tb_rc4_stream_cipher_core.sv
module tb_rc4_stream_cipher_core;
	timeunit 1ns;
	timeprecision 1ps;

	import rc4_pkg::*;

	localparam int unsigned CycleLimit  = 1_000_000;
	localparam int unsigned RandomItems = 1600;
	localparam int unsigned DrainCycles = 40;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cmd_valid = 1'b0;
	cmd_t        cmd       = '0;
	logic        rsp_stall = 1'b0;
	logic        cmd_stall;
	logic        rsp_valid;
	rsp_t        rsp;
	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;
	int unsigned sent_cnt  = 0;
	int unsigned cycle_cnt = 0;
	int unsigned fail_cnt;
	int unsigned pending;

	rc4_stream_cipher_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	rc4_stream_cipher_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.fail_cnt  (fail_cnt),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk)
		rsp_stall <= ($urandom_range(99) < stall_pct);

	task automatic push_cmd(input cmd_t c);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		sent_cnt++;
	endtask

	task automatic load_key(input logic [7:0] idx, input logic [7:0] kbyte);
		cmd_t c;
		c.operation = OpKeyLoad;
		c.key_index = idx;
		c.data_byte = kbyte;
		c.zone_end = 1'($urandom_range(1));
		push_cmd(c);
	endtask

	task automatic send_data(input logic [7:0] dbyte, input logic zend);
		cmd_t c;
		c.operation = OpData;
		c.key_index = 8'($urandom_range(255));
		c.data_byte = dbyte;
		c.zone_end = zend;
		push_cmd(c);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		int unsigned r;
		int unsigned n;
		int unsigned len;
		int unsigned phase_end;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// unkeyed pass-through, zone end while unkeyed, key load with a random zone end
		send_data(8'h00, 1'b0);
		send_data(8'hFF, 1'b1);
		load_key(8'h00, 8'hFF);
		// first key must fill the whole store
		for (int k = 0; k < KeyLength; k++)
			load_key(8'(k), 8'($urandom_range(255)));
		send_data(8'h00, 1'b0);
		send_data(8'hFF, 1'b0);
		send_data(8'hA5, 1'b0);
		wait_drained();
		// rekey while keyed restarts the keystream
		load_key(KeyLast, 8'h00);
		send_data(8'h00, 1'b0);
		send_data(8'hFF, 1'b0);
		send_data(8'h3C, 1'b1);
		send_data(8'h5A, 1'b0);
		load_key(KeyLast, 8'hFF);
		send_data(8'hFF, 1'b1);
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 88; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 88; end
				default: begin idle_pct = 30; stall_pct = 30; end
			endcase
			phase_end = sent_cnt + RandomItems / 4;
			while (sent_cnt < phase_end) begin
				r = $urandom_range(99);
				if (r < 75) begin
					n = $urandom_range(4);
					repeat (n)
						load_key(8'($urandom_range(254)), 8'($urandom_range(255)));
					load_key(KeyLast, 8'($urandom_range(255)));
					len = $urandom_range(40, 1);
					for (int k = 0; k < len; k++)
						send_data(8'($urandom_range(255)),
							(k == len - 1) && ($urandom_range(9) != 0));
				end else if (r < 90) begin
					send_data(8'($urandom_range(255)), 1'($urandom_range(1)));
				end else begin
					load_key(8'($urandom_range(255)), 8'($urandom_range(255)));
				end
			end
			wait_drained();
		end

		@(negedge clk);
		cmd_valid <= 1'b0;
		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		if (fail_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
